>>> src/lsrg_pkg.sv
// shared types and constants for the link stall recovery guard
package lsrg_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FREEZE_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRACE         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEALTHY_CLEAR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTCONN_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STREAK    = 3'd4;

  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_FROZEN  = 2'd1;
  localparam logic [1:0] CAUSE_NOTCONN = 2'd2;

  localparam logic [31:0] FREEZE_LIMIT_RST  = 32'd60000;
  localparam logic [31:0] GRACE_RST         = 32'd10000;
  localparam logic [31:0] HEALTHY_CLEAR_RST = 32'd1800000;
  localparam logic [15:0] NOTCONN_LIMIT_RST = 16'd10;
  localparam logic [7:0]  MAX_STREAK_RST    = 8'd3;

  typedef struct packed {
    logic [31:0] freeze_limit_ms;
    logic [31:0] grace_ms;
    logic [31:0] healthy_clear_ms;
    logic [15:0] notconn_limit;
    logic [7:0]  max_streak;
  } lsrg_cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [31:0] link_epoch;
    logic        is_connected;
    logic        is_subscribed;
    logic [31:0] session_start_ms;
    logic [31:0] delivered_total;
    logic [31:0] notconn_run;
  } lsrg_item_t;

  typedef struct packed {
    logic [31:0] seen_epoch;
    logic        seeded;
    logic [31:0] last_delivered;
    logic [31:0] progress_time;
    logic [31:0] healthy_start;
    logic [7:0]  streak;
    logic        latched;
    logic [31:0] resets;
    logic [1:0]  cause;
    logic [31:0] frozen_record;
  } lsrg_state_t;

  typedef struct packed {
    logic        reset_request;
    logic [1:0]  trigger_cause;
    logic [31:0] frozen_time_ms;
    logic [31:0] reset_total;
    logic [7:0]  reset_streak;
    logic        gave_up;
  } lsrg_result_t;

endpackage

>>> src/lsrg_step.sv
// per-tick update of the guard state and the result it shows
module lsrg_step (
  input  lsrg_pkg::lsrg_cfg_t    cfg,
  input  lsrg_pkg::lsrg_item_t   item,
  input  lsrg_pkg::lsrg_state_t  st,
  output lsrg_pkg::lsrg_state_t  st_nxt,
  output lsrg_pkg::lsrg_result_t res
);
  import lsrg_pkg::*;

  lsrg_state_t s;
  logic        req;

  always_comb begin
    logic        armed;
    logic        handled;
    logic [31:0] conn_age;
    logic [31:0] heal_age;
    logic [31:0] frozen;
    s       = st;
    req     = 1'b0;
    handled = 1'b0;
    frozen  = '0;
    if (item.link_epoch != s.seen_epoch) begin
      s.seen_epoch = item.link_epoch;
      s.seeded     = 1'b0;
    end
    conn_age = item.now_ms - item.session_start_ms;
    heal_age = item.now_ms - s.healthy_start;
    armed    = item.is_connected && item.is_subscribed && (conn_age >= cfg.grace_ms);
    if (!armed) begin
      s.seeded = 1'b0;
    end else if (!s.seeded) begin
      s.last_delivered = item.delivered_total;
      s.progress_time  = item.now_ms;
      s.seeded         = 1'b1;
    end else begin
      if (item.delivered_total != s.last_delivered) begin
        s.last_delivered = item.delivered_total;
        s.progress_time  = item.now_ms;
        if (s.healthy_start == '0) begin
          s.healthy_start = item.now_ms;
        end else if ((s.streak != '0) && (heal_age >= cfg.healthy_clear_ms)) begin
          s.streak  = '0;
          s.latched = 1'b0;
        end
      end else begin
        frozen          = item.now_ms - s.progress_time;
        s.healthy_start = '0;
        if (frozen >= cfg.freeze_limit_ms) begin
          if (s.streak >= cfg.max_streak) begin
            s.latched = 1'b1;
          end else begin
            req             = 1'b1;
            s.resets        = s.resets + 32'd1;
            s.streak        = s.streak + 8'd1;
            s.cause         = CAUSE_FROZEN;
            s.frozen_record = frozen;
          end
          s.seeded = 1'b0;
          handled  = 1'b1;
        end
      end
      // not-connected streak, skipped once the freeze check fired
      if (!handled && item.is_connected &&
          (item.notconn_run >= {16'd0, cfg.notconn_limit})) begin
        if (s.streak >= cfg.max_streak) begin
          s.latched = 1'b1;
        end else begin
          req             = 1'b1;
          s.resets        = s.resets + 32'd1;
          s.streak        = s.streak + 8'd1;
          s.cause         = CAUSE_NOTCONN;
          s.frozen_record = item.now_ms - s.progress_time;
        end
        s.seeded = 1'b0;
      end
    end
  end

  assign st_nxt = s;

  assign res.reset_request  = req;
  assign res.trigger_cause  = s.cause;
  assign res.frozen_time_ms = s.frozen_record;
  assign res.reset_total    = s.resets;
  assign res.reset_streak   = s.streak;
  assign res.gave_up        = s.latched;

endmodule

>>> src/link_stall_recovery_guard_core.sv
// link stall recovery guard: request capture, tick update and result register
// flow: a request accepted into the capture register is processed once the result
//   register is free or being read, then its result is offered from that register
// throughput: one request per cycle while out_ready keeps the result register free
// reset: synchronous active-low rst_n clears all guard state, loads the default
//   limits and empties the request and result registers
module link_stall_recovery_guard_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_link_epoch,
  input  logic        in_is_connected,
  input  logic        in_is_subscribed,
  input  logic [31:0] in_session_start_ms,
  input  logic [31:0] in_delivered_total,
  input  logic [31:0] in_notconn_run,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_reset_request,
  output logic [1:0]  out_trigger_cause,
  output logic [31:0] out_frozen_time_ms,
  output logic [31:0] out_reset_total,
  output logic [7:0]  out_reset_streak,
  output logic        out_gave_up,
  input  logic        cfg_we,
  input  logic [lsrg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_wdata
);
  import lsrg_pkg::*;

  lsrg_cfg_t    cfg_r;
  lsrg_item_t   item_r;
  logic         in_v_r;
  lsrg_state_t  st_r;
  lsrg_state_t  st_nxt;
  lsrg_result_t res_nxt;
  lsrg_result_t res_r;
  logic         out_v_r;
  logic         fire;

  assign fire     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.freeze_limit_ms  <= FREEZE_LIMIT_RST;
      cfg_r.grace_ms         <= GRACE_RST;
      cfg_r.healthy_clear_ms <= HEALTHY_CLEAR_RST;
      cfg_r.notconn_limit    <= NOTCONN_LIMIT_RST;
      cfg_r.max_streak       <= MAX_STREAK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FREEZE_LIMIT:  cfg_r.freeze_limit_ms  <= cfg_wdata;
        CFG_GRACE:         cfg_r.grace_ms         <= cfg_wdata;
        CFG_HEALTHY_CLEAR: cfg_r.healthy_clear_ms <= cfg_wdata;
        CFG_NOTCONN_LIMIT: cfg_r.notconn_limit    <= cfg_wdata[15:0];
        CFG_MAX_STREAK:    cfg_r.max_streak       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.now_ms           <= in_now_ms;
      item_r.link_epoch       <= in_link_epoch;
      item_r.is_connected     <= in_is_connected;
      item_r.is_subscribed    <= in_is_subscribed;
      item_r.session_start_ms <= in_session_start_ms;
      item_r.delivered_total  <= in_delivered_total;
      item_r.notconn_run      <= in_notconn_run;
    end
  end

  lsrg_step u_step (
    .cfg    (cfg_r),
    .item   (item_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // guard state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (fire) begin
        st_r <= st_nxt;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_v_r;
  assign out_reset_request  = res_r.reset_request;
  assign out_trigger_cause  = res_r.trigger_cause;
  assign out_frozen_time_ms = res_r.frozen_time_ms;
  assign out_reset_total    = res_r.reset_total;
  assign out_reset_streak   = res_r.reset_streak;
  assign out_gave_up        = res_r.gave_up;

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_nxt.reset_request |=> st_r.resets == $past(st_r.resets) + 32'd1)
    else $error("reset total did not advance with a reset request");

  a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !res_nxt.reset_request |=> st_r.resets == $past(st_r.resets))
    else $error("reset total moved without a reset request");

  a_state_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(st_r))
    else $error("guard state changed with no request processed");

  a_cause_set: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_nxt.reset_request |->
      (res_nxt.trigger_cause == CAUSE_FROZEN || res_nxt.trigger_cause == CAUSE_NOTCONN))
    else $error("reset request with no cause recorded");

  a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
    !in_v_r |-> in_ready)
    else $error("capture register empty but not ready");

endmodule
